// File: rtl/core/tfdc_pkg.sv
package tfdc_pkg;

   localparam int DUTY_W     = 7;
   localparam int SEG_OUT_W  = 4;
   localparam int FIELD_W    = 16;
   localparam int QUOT_W     = 7;
   localparam int PROD_W     = 14;
   localparam int SCALED_W   = 27;

   localparam logic FUNC_WRITE   = 1'b0;
   localparam logic FUNC_CONVERT = 1'b1;

   localparam logic MODE_STEPPED = 1'b0;
   localparam logic MODE_INTERP  = 1'b1;

   localparam logic [DUTY_W-1:0] DUTY_ZERO = 7'd0;
   localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

   // x / 100 == (x * 5243) >> 19 for every x below 10000
   localparam logic [SCALED_W-1:0] RECIP_100   = 27'd5243;
   localparam int                  RECIP_SHIFT = 19;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic                  func;
      logic [3:0]            bp_index;
      logic [FIELD_W-1:0]    bp_value;
      logic [FIELD_W-1:0]    temperature;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0]     duty_percent;
      logic [SEG_OUT_W-1:0]  segment;
   } rsp_type;

   // per-convert control carried from front to back
   typedef struct packed {
      logic                  interp;
      logic [DUTY_W-1:0]     direct_duty;
      logic [DUTY_W-1:0]     lo_dc;
      logic [DUTY_W-1:0]     dc_diff;
      logic [SEG_OUT_W-1:0]  segment;
   } ctx_type;

endpackage

// File: rtl/core/temp_to_fan_duty_curve.sv
// Temperature to fan duty curve. A req beat with func set to write stores one
// breakpoint temperature (indexes past the table are dropped); a convert beat
// returns one rsp beat with the duty in percent and the segment, in order. The
// csr port selects stepped tens (0) or linear interpolation (1, the reset
// value). One beat is taken per clock while the queue has room: the front does
// the table compare and priority encode in the accept cycle, a four-entry queue
// decouples it from the back pipeline, and the back runs one quotient bit per
// stage. A stalled rsp beat freezes the whole back pipeline until it leaves.
// Writes take effect for every convert accepted after them. The table resets
// to all zero.
module temp_to_fan_duty_curve #(
   parameter int TEMP_BITS       = 16,
   parameter int NUM_BREAKPOINTS = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tfdc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tfdc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   localparam int CTX_W  = $bits(tfdc_pkg::ctx_type);
   localparam int DATA_W = CTX_W + 3 * TEMP_BITS;

   logic                 fq_valid, fq_ready;
   tfdc_pkg::ctx_type    fq_ctx;
   logic [TEMP_BITS-1:0] fq_temp, fq_lo, fq_hi;

   logic                 qb_valid, qb_ready;
   logic [DATA_W-1:0]    qb_data;
   tfdc_pkg::ctx_type    qb_ctx;
   logic [TEMP_BITS-1:0] qb_temp, qb_lo, qb_hi;

   tfdc_front #(
      .TEMP_BITS       (TEMP_BITS),
      .NUM_BREAKPOINTS (NUM_BREAKPOINTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_valid   (fq_valid),
      .q_ready   (fq_ready),
      .q_ctx     (fq_ctx),
      .q_temp    (fq_temp),
      .q_lo      (fq_lo),
      .q_hi      (fq_hi)
   );

   tfdc_queue #(
      .DATA_W (DATA_W),
      .DEPTH  (tfdc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   ({fq_ctx, fq_temp, fq_lo, fq_hi}),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   assign {qb_ctx, qb_temp, qb_lo, qb_hi} = qb_data;

   tfdc_back #(
      .TEMP_BITS (TEMP_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (qb_valid),
      .in_ready  (qb_ready),
      .in_ctx    (qb_ctx),
      .in_temp   (qb_temp),
      .in_lo     (qb_lo),
      .in_hi     (qb_hi),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/core/tfdc_front.sv
module tfdc_front #(
   parameter int TEMP_BITS       = 16,
   parameter int NUM_BREAKPOINTS = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tfdc_pkg::req_type      req_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_data,
   output logic                   q_valid,
   input  logic                   q_ready,
   output tfdc_pkg::ctx_type      q_ctx,
   output logic [TEMP_BITS-1:0]   q_temp,
   output logic [TEMP_BITS-1:0]   q_lo,
   output logic [TEMP_BITS-1:0]   q_hi
);

   localparam int IDX_W = (NUM_BREAKPOINTS > 1) ? $clog2(NUM_BREAKPOINTS) : 1;
   localparam int SEG_W = $clog2(NUM_BREAKPOINTS + 1);

   logic [TEMP_BITS-1:0]        table_ff [NUM_BREAKPOINTS];
   logic                        mode_ff;
   logic [tfdc_pkg::DUTY_W-1:0] duty_tab [NUM_BREAKPOINTS];

   logic                        accept;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_idx;
   logic [TEMP_BITS-1:0]        wr_val;
   logic [TEMP_BITS-1:0]        temp;
   logic [NUM_BREAKPOINTS-1:0]  lt;
   logic [SEG_W-1:0]            seg;
   logic [IDX_W-1:0]            step_idx;
   logic                        interior;
   logic [IDX_W-1:0]            lo_idx;
   logic [IDX_W-1:0]            hi_idx;

   for (genvar k = 0; k < NUM_BREAKPOINTS; k++) begin : g_duty
      localparam int DutyK = (k * 100) / (NUM_BREAKPOINTS - 1);
      assign duty_tab[k] = tfdc_pkg::DUTY_W'(DutyK);
   end

   assign req_ready = q_ready;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   assign wr_en  = accept && (req_data.func == tfdc_pkg::FUNC_WRITE) &&
                   (6'(req_data.bp_index) < 6'(NUM_BREAKPOINTS));
   assign wr_idx = IDX_W'(req_data.bp_index);
   assign wr_val = TEMP_BITS'(req_data.bp_value);
   assign temp   = TEMP_BITS'(req_data.temperature);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tfdc_pkg::MODE_INTERP;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data;
      end
   end

   for (genvar i = 0; i < NUM_BREAKPOINTS; i++) begin : g_tab
      always_ff @(posedge clock) begin
         if (reset) begin
            table_ff[i] <= '0;
         end else if (wr_en && (wr_idx == IDX_W'(i))) begin
            table_ff[i] <= wr_val;
         end
      end
      assign lt[i] = temp < table_ff[i];
   end

   // priority encode: first breakpoint above the temperature
   always_comb begin
      seg      = SEG_W'(NUM_BREAKPOINTS);
      step_idx = IDX_W'(NUM_BREAKPOINTS - 1);
      for (int i = NUM_BREAKPOINTS - 1; i >= 0; i--) begin
         if (lt[i]) begin
            seg = SEG_W'(i);
         end
      end
      // stepped mode skips breakpoint 0
      for (int i = NUM_BREAKPOINTS - 1; i >= 1; i--) begin
         if (lt[i]) begin
            step_idx = IDX_W'(i - 1);
         end
      end
   end

   assign interior = (seg != '0) && (seg != SEG_W'(NUM_BREAKPOINTS));
   assign lo_idx   = interior ? IDX_W'(seg - 1'b1) : '0;
   assign hi_idx   = interior ? IDX_W'(seg) : '0;

   always_comb begin
      q_ctx         = '0;
      q_ctx.segment = tfdc_pkg::SEG_OUT_W'(seg);
      q_ctx.lo_dc   = duty_tab[lo_idx];
      q_ctx.dc_diff = duty_tab[hi_idx] - duty_tab[lo_idx];
      q_ctx.interp  = 1'b0;
      if (mode_ff == tfdc_pkg::MODE_STEPPED) begin
         q_ctx.direct_duty = duty_tab[step_idx];
      end else if (seg == '0) begin
         q_ctx.direct_duty = tfdc_pkg::DUTY_ZERO;
      end else if (!interior) begin
         q_ctx.direct_duty = tfdc_pkg::DUTY_FULL;
      end else begin
         q_ctx.direct_duty = tfdc_pkg::DUTY_ZERO;
         q_ctx.interp      = 1'b1;
      end
   end

   assign q_valid = req_valid && (req_data.func == tfdc_pkg::FUNC_CONVERT);
   assign q_temp  = temp;
   assign q_lo    = table_ff[lo_idx];
   assign q_hi    = table_ff[hi_idx];

endmodule

// File: rtl/core/tfdc_queue.sv
module tfdc_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: rtl/core/tfdc_back.sv
module tfdc_back #(
   parameter int TEMP_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tfdc_pkg::ctx_type    in_ctx,
   input  logic [TEMP_BITS-1:0] in_temp,
   input  logic [TEMP_BITS-1:0] in_lo,
   input  logic [TEMP_BITS-1:0] in_hi,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tfdc_pkg::rsp_type    rsp_data
);

   localparam int QW    = tfdc_pkg::QUOT_W;
   localparam int NUM_W = TEMP_BITS + QW;

   logic advance;

   // operand stage
   logic                 s0_v_ff;
   tfdc_pkg::ctx_type    s0_ctx_ff;
   logic [TEMP_BITS-1:0] s0_diff_ff;
   logic [TEMP_BITS-1:0] s0_span_ff;

   // quotient stages, index 0 holds the scaled numerator
   logic [QW:0]          dv_ff;
   tfdc_pkg::ctx_type    dctx_ff [QW+1];
   logic [NUM_W-1:0]     drem_ff [QW+1];
   logic [TEMP_BITS-1:0] dden_ff [QW+1];
   logic [QW-1:0]        dq_ff   [QW+1];

   logic                          mul_v_ff;
   tfdc_pkg::ctx_type             mul_ctx_ff;
   logic [tfdc_pkg::PROD_W-1:0]   mul_prod_ff;

   logic                          sc_v_ff;
   tfdc_pkg::ctx_type             sc_ctx_ff;
   logic [tfdc_pkg::SCALED_W-1:0] scaled;
   logic [tfdc_pkg::DUTY_W-1:0]   sc_step_ff;

   logic                          rsp_valid_ff;
   tfdc_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic [tfdc_pkg::DUTY_W:0]     sum;

   // whole pipe moves together when the output beat is free or leaving
   assign advance  = !rsp_valid_ff || rsp_ready;
   assign in_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         dv_ff[0] <= 1'b0;
         mul_v_ff <= 1'b0;
         sc_v_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_v_ff  <= in_valid;
         dv_ff[0] <= s0_v_ff;
         mul_v_ff <= dv_ff[QW];
         sc_v_ff  <= mul_v_ff;
         rsp_valid_ff <= sc_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ctx_ff  <= in_ctx;
         s0_diff_ff <= in_temp - in_lo;
         s0_span_ff <= in_hi - in_lo;
         // diff * 100 as shifts and adds
         dctx_ff[0] <= s0_ctx_ff;
         drem_ff[0] <= (NUM_W'(s0_diff_ff) << 6) + (NUM_W'(s0_diff_ff) << 5) +
                       (NUM_W'(s0_diff_ff) << 2);
         dden_ff[0] <= s0_span_ff;
         dq_ff[0]   <= '0;
      end
   end

   // restoring division, one quotient bit per stage; quotient stays below 100 for interpolated beats
   for (genvar k = 0; k < QW; k++) begin : g_div
      localparam int Shift = QW - 1 - k;
      logic [NUM_W-1:0] trial;
      logic             take;

      assign trial = NUM_W'(dden_ff[k]) << Shift;
      assign take  = drem_ff[k] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (advance) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dctx_ff[k+1] <= dctx_ff[k];
            dden_ff[k+1] <= dden_ff[k];
            drem_ff[k+1] <= take ? drem_ff[k] - trial : drem_ff[k];
            dq_ff[k+1]   <= dq_ff[k] | (take ? (QW'(1) << Shift) : QW'(0));
         end
      end
   end

   assign scaled = tfdc_pkg::SCALED_W'(mul_prod_ff) * tfdc_pkg::RECIP_100;

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_ctx_ff  <= dctx_ff[QW];
         mul_prod_ff <= tfdc_pkg::PROD_W'(dctx_ff[QW].dc_diff) *
                        tfdc_pkg::PROD_W'(dq_ff[QW]);
         sc_ctx_ff   <= mul_ctx_ff;
         sc_step_ff  <= tfdc_pkg::DUTY_W'(scaled >> tfdc_pkg::RECIP_SHIFT);
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign sum = {1'b0, sc_ctx_ff.lo_dc} + {1'b0, sc_step_ff};

   always_comb begin
      rsp_data_in.segment = sc_ctx_ff.segment;
      if (!sc_ctx_ff.interp) begin
         rsp_data_in.duty_percent = sc_ctx_ff.direct_duty;
      end else if (sum > {1'b0, tfdc_pkg::DUTY_FULL}) begin
         rsp_data_in.duty_percent = tfdc_pkg::DUTY_FULL;
      end else begin
         rsp_data_in.duty_percent = sum[tfdc_pkg::DUTY_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/tfdc_checker.sv
module tfdc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input tfdc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tfdc_pkg::rsp_type rsp_data
);

   logic [7:0] pending_ff, pending_in;
   logic       conv_beat, rsp_beat;

   assign conv_beat = req_valid && req_ready && (req_data.func == tfdc_pkg::FUNC_CONVERT);
   assign rsp_beat  = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (conv_beat && !rsp_beat) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_beat && !conv_beat) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("rsp_valid right after reset");

   // a result needs a convert beat that has not yet been answered
   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("rsp beat without pending convert");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.duty_percent <= tfdc_pkg::DUTY_FULL)
      else $error("duty above full scale");

endmodule

bind temp_to_fan_duty_curve tfdc_checker u_tfdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
